/* hdl/ctp_pkg.sv */
// ---------------------------------------------------------------------------
// ctp_pkg
// Shared constants, piece codes and widths for the clipmap tile placement
// block.
// ---------------------------------------------------------------------------
package ctp_pkg;

    localparam int MAX_LEVELS = 4;
    localparam int FRAC_BITS  = 12;

    // Divider shift: cam * 256 / (spacing << FRAC_BITS) = cam / (spacing << DIV_SHIFT).
    localparam int DIV_SHIFT = FRAC_BITS - 8;
    // Output positions are Q.9 values rescaled to FRAC_BITS.
    localparam int POS_SHIFT = FRAC_BITS - 9;

    localparam int CAM_W   = 32;
    localparam int SPC_W   = 16;
    localparam int RING_W  = 9;
    localparam int LVC_W   = 3;
    localparam int LVL_W   = 2;
    localparam int DEN_W   = SPC_W + DIV_SHIFT;
    localparam int Q_W     = CAM_W - DIV_SHIFT + 1;
    localparam int PROD_W  = Q_W + SPC_W + 1;
    localparam int T0_W    = RING_W + SPC_W;
    localparam int TL_W    = T0_W + MAX_LEVELS - 1;
    localparam int ADD_W   = TL_W + 4;
    localparam int POS_W   = 48;
    localparam int SCALE_W = 19;
    localparam int IDX_W   = 6;
    localparam int PIECE_W = 3;
    localparam int ROT_W   = 2;
    localparam int CNT_W   = 5;

    localparam logic [PIECE_W-1:0] PIECE_CROSS  = 3'd0;
    localparam logic [PIECE_W-1:0] PIECE_TILE   = 3'd1;
    localparam logic [PIECE_W-1:0] PIECE_FILLER = 3'd2;
    localparam logic [PIECE_W-1:0] PIECE_TRIM   = 3'd3;
    localparam logic [PIECE_W-1:0] PIECE_SEAM   = 3'd4;

    localparam logic [1:0] REG_SPACING     = 2'd0;
    localparam logic [1:0] REG_RING_SIZE   = 2'd1;
    localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

    // One placement as it leaves the sequencer.
    typedef struct packed {
        logic [PIECE_W-1:0] piece;
        logic [IDX_W-1:0]   idx;
        logic [2:0]         snap_shift;
        logic [LVL_W-1:0]   lvl;
        logic [1:0]         gx;
        logic [1:0]         gz;
        logic [ROT_W-1:0]   rot;
        logic               last;
    } ctp_desc_t;

endpackage

/* hdl/clipmap_tile_placement.sv */
// ---------------------------------------------------------------------------
// clipmap_tile_placement
// Emits the placements of geometry clipmap terrain pieces for a camera
// position: cross, per-level tiles, filler, trim and seam.
// ---------------------------------------------------------------------------
// Usage:
// One slave transaction carries a camera position; the block answers with a
// run of master transactions, one per placement, tlast marking the final one
// (up to 63 placements with four levels). The piece kind travels on tuser.
// A serial floor divider snaps both axes, one quotient bit per cycle; the
// snapped position then goes to the placement sequencer, which issues one
// placement per cycle, unless the receiver stalls it, into a three-stage
// pipeline (descriptor, multiply, output register). A new camera position is
// taken as soon as the divider is free, so its division overlaps the emission
// of the previous run. The user must write the registers through
// cfg_wen/cfg_addr/cfg_wdata only while the block is idle; the block itself
// does not enforce this. Reset clears all valid and busy flags and loads
// spacing 256, ring size 32 and four levels. When the receiver holds tready
// low, the whole placement pipeline freezes with the pending placement held
// in the output register; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module clipmap_tile_placement
    import ctp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // cam_x[31:0], cam_z[63:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // piece_index[5:0], pos_x[53:6], pos_z[101:54],
                                         // piece_scale[120:102], rotation[122:121], zeros
    output logic [2:0]   m_axis_tuser,   // piece
    output logic         m_axis_tlast
);

    localparam logic [2:0] PH_CROSS  = 3'd0;
    localparam logic [2:0] PH_TILE   = 3'd1;
    localparam logic [2:0] PH_FILLER = 3'd2;
    localparam logic [2:0] PH_TRIM   = 3'd3;
    localparam logic [2:0] PH_SEAM   = 3'd4;

    // Configuration registers.
    logic [SPC_W-1:0]  spacing_reg;
    logic [RING_W-1:0] ring_size_reg;
    logic [LVC_W-1:0]  level_count_reg;
    logic [T0_W-1:0]   t0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg     <= SPC_W'(256);
            ring_size_reg   <= RING_W'(32);
            level_count_reg <= LVC_W'(4);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_SPACING:     spacing_reg     <= cfg_wdata;
                REG_RING_SIZE:   ring_size_reg   <= cfg_wdata[RING_W-1:0];
                REG_LEVEL_COUNT: level_count_reg <= cfg_wdata[LVC_W-1:0];
                default:         ;
            endcase
        end
    end

    // Tile size at level 0, in units of spacing * vertices.
    always_ff @(posedge clk)
    begin
        t0_reg <= T0_W'(ring_size_reg) * T0_W'(spacing_reg);
    end

    // Serial floor divider, both axes side by side.
    logic               div_busy_reg, div_done_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic [CAM_W-1:0]   ax_reg, az_reg;
    logic [DEN_W-1:0]   remx_reg, remz_reg;
    logic               negx_reg, negz_reg;
    logic signed [Q_W-1:0] qx_res_reg, qz_res_reg;
    logic [DEN_W:0]     shx, shz;
    logic [DEN_W:0]     den;
    logic signed [CAM_W-1:0] cam_x, cam_z;
    logic [Q_W-1:0]     qx_fin, qz_fin;
    logic               seq_load;

    assign cam_x         = s_axis_tdata[31:0];
    assign cam_z         = s_axis_tdata[63:32];
    assign s_axis_tready = !div_busy_reg && !div_done_reg;
    assign den           = {1'b0, spacing_reg, {DIV_SHIFT{1'b0}}};
    assign shx           = {remx_reg, ax_reg[CAM_W-1]};
    assign shz           = {remz_reg, az_reg[CAM_W-1]};

    always_comb
    begin
        qx_fin = ax_reg[Q_W-1:0];
        qz_fin = az_reg[Q_W-1:0];
        if (negx_reg)
        begin
            qx_fin = -(qx_fin + Q_W'(remx_reg != '0));
        end
        if (negz_reg)
        begin
            qz_fin = -(qz_fin + Q_W'(remz_reg != '0));
        end
        if (spacing_reg == '0)
        begin
            qx_fin = '0;
            qz_fin = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == '1)
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
            else if (seq_load)
            begin
                div_done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ax_reg   <= cam_x[CAM_W-1] ? CAM_W'(-cam_x) : cam_x;
            az_reg   <= cam_z[CAM_W-1] ? CAM_W'(-cam_z) : cam_z;
            negx_reg <= cam_x[CAM_W-1];
            negz_reg <= cam_z[CAM_W-1];
            remx_reg <= '0;
            remz_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (shx >= den)
            begin
                remx_reg <= DEN_W'(shx - den);
                ax_reg   <= {ax_reg[CAM_W-2:0], 1'b1};
            end
            else
            begin
                remx_reg <= shx[DEN_W-1:0];
                ax_reg   <= {ax_reg[CAM_W-2:0], 1'b0};
            end
            if (shz >= den)
            begin
                remz_reg <= DEN_W'(shz - den);
                az_reg   <= {az_reg[CAM_W-2:0], 1'b1};
            end
            else
            begin
                remz_reg <= shz[DEN_W-1:0];
                az_reg   <= {az_reg[CAM_W-2:0], 1'b0};
            end
            if (div_cnt_reg == '1)
            begin
                qx_res_reg <= '0;
                qz_res_reg <= '0;
            end
        end
        else if (div_done_reg)
        begin
            qx_res_reg <= qx_fin;
            qz_res_reg <= qz_fin;
        end
    end

    // Placement sequencer.
    logic                  en;
    logic                  seq_busy_reg;
    logic [2:0]            phase_reg;
    logic [LVL_W-1:0]      lvl_reg, lv_last_reg;
    logic [1:0]            tx_reg, ty_reg;
    logic [IDX_W-1:0]      tile_cnt_reg;
    logic signed [Q_W-1:0] qx0_reg, qz0_reg;
    logic [LVL_W-1:0]      lv_last;
    logic                  res_ok_reg;
    ctp_desc_t             desc;
    logic                  desc_end;

    // The quotient is final in the cycle after the divider reports done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ok_reg <= 1'b0;
        end
        else
        begin
            res_ok_reg <= div_done_reg && !seq_load;
        end
    end

    // A new run loads only while the pipeline moves, so the snapped position
    // of a placement still held in the descriptor stage is not replaced.
    assign seq_load = !seq_busy_reg && div_done_reg && res_ok_reg && en;

    always_comb
    begin
        priority if (level_count_reg == '0)
        begin
            lv_last = '0;
        end
        else if (level_count_reg > LVC_W'(MAX_LEVELS))
        begin
            lv_last = LVL_W'(MAX_LEVELS - 1);
        end
        else
        begin
            lv_last = LVL_W'(level_count_reg - 1'b1);
        end
    end

    always_comb
    begin
        desc.piece      = PIECE_CROSS;
        desc.idx        = '0;
        desc.snap_shift = {1'b0, lvl_reg};
        desc.lvl        = lvl_reg;
        desc.gx         = tx_reg;
        desc.gz         = ty_reg;
        desc.rot        = '0;
        desc.last       = 1'b0;
        desc_end        = 1'b0;
        unique case (phase_reg)
            PH_CROSS:
            begin
                desc.piece      = PIECE_CROSS;
                desc.snap_shift = '0;
            end
            PH_TILE:
            begin
                desc.piece = PIECE_TILE;
                desc.idx   = tile_cnt_reg;
            end
            PH_FILLER:
            begin
                desc.piece = PIECE_FILLER;
                desc.idx   = IDX_W'(lvl_reg);
                desc.last  = (lvl_reg == lv_last_reg);
                desc_end   = desc.last;
            end
            PH_TRIM:
            begin
                desc.piece = PIECE_TRIM;
                desc.idx   = IDX_W'(lvl_reg);
                desc.rot   = {~qx0_reg[lvl_reg], ~qz0_reg[lvl_reg]};
            end
            PH_SEAM:
            begin
                desc.piece      = PIECE_SEAM;
                desc.idx        = IDX_W'(lvl_reg);
                desc.snap_shift = 3'(lvl_reg) + 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg <= 1'b0;
            phase_reg    <= PH_CROSS;
            lvl_reg      <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            tile_cnt_reg <= '0;
            lv_last_reg  <= '0;
        end
        else if (seq_load)
        begin
            seq_busy_reg <= 1'b1;
            phase_reg    <= PH_CROSS;
            lvl_reg      <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            tile_cnt_reg <= '0;
            lv_last_reg  <= lv_last;
        end
        else if (seq_busy_reg && en)
        begin
            unique case (phase_reg)
                PH_CROSS:
                begin
                    phase_reg <= PH_TILE;
                end
                PH_TILE:
                begin
                    tile_cnt_reg <= tile_cnt_reg + 1'b1;
                    if (tx_reg == 2'd3 && ty_reg == 2'd3)
                    begin
                        phase_reg <= PH_FILLER;
                    end
                    if (ty_reg == 2'd3)
                    begin
                        tx_reg <= tx_reg + 1'b1;
                        ty_reg <= '0;
                    end
                    else if (lvl_reg != '0 && (tx_reg == 2'd1 || tx_reg == 2'd2))
                    begin
                        ty_reg <= 2'd3;
                    end
                    else
                    begin
                        ty_reg <= ty_reg + 1'b1;
                    end
                end
                PH_FILLER:
                begin
                    if (desc_end)
                    begin
                        seq_busy_reg <= 1'b0;
                    end
                    else
                    begin
                        phase_reg <= PH_TRIM;
                    end
                end
                PH_TRIM:
                begin
                    phase_reg <= PH_SEAM;
                end
                PH_SEAM:
                begin
                    phase_reg <= PH_TILE;
                    lvl_reg   <= lvl_reg + 1'b1;
                    tx_reg    <= '0;
                    ty_reg    <= '0;
                end
                default:
                begin
                    phase_reg <= PH_CROSS;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            qx0_reg <= qx_res_reg;
            qz0_reg <= qz_res_reg;
        end
    end

    // Stage 1: descriptor register.
    logic      d_valid_reg;
    ctp_desc_t d_reg;

    assign en = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= seq_busy_reg && !seq_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= desc;
        end
    end

    // Stage 2: snapped products and offsets.
    logic [Q_W-1:0]           snap_mask;
    logic signed [Q_W-1:0]    mx, mz;
    logic [TL_W-1:0]          tl;
    logic [SCALE_W-1:0]       sc;
    logic signed [ADD_W-1:0]  addx, addz;
    logic signed [ADD_W-1:0]  tls, scs;

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] px_reg, pz_reg;
    logic signed [ADD_W-1:0]  addx_reg, addz_reg;
    logic [SCALE_W-1:0]       scale_reg;
    ctp_desc_t                p_reg;

    function automatic logic signed [ADD_W-1:0] tile_off(
        input logic [1:0] g,
        input logic signed [ADD_W-1:0] t,
        input logic signed [ADD_W-1:0] s
    );
        logic signed [ADD_W-1:0] o;
        unique case (g)
            2'd0:    o = -(t <<< 1);
            2'd1:    o = -t;
            2'd2:    o = s;
            default: o = t + s;
        endcase
        return o <<< 1;
    endfunction

    always_comb
    begin
        snap_mask = {Q_W{1'b1}} << d_reg.snap_shift;
        mx        = qx0_reg & snap_mask;
        mz        = qz0_reg & snap_mask;
        tl        = TL_W'(t0_reg) << d_reg.lvl;
        sc        = SCALE_W'(spacing_reg) << d_reg.lvl;
        tls       = ADD_W'(tl);
        scs       = ADD_W'(sc);
        unique case (d_reg.piece)
            PIECE_TILE:
            begin
                addx = tile_off(d_reg.gx, tls, scs);
                addz = tile_off(d_reg.gz, tls, scs);
            end
            PIECE_TRIM:
            begin
                addx = scs;
                addz = scs;
            end
            PIECE_SEAM:
            begin
                addx = -(tls <<< 2);
                addz = -(tls <<< 2);
            end
            default:
            begin
                addx = '0;
                addz = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= mx * $signed({1'b0, spacing_reg});
            pz_reg    <= mz * $signed({1'b0, spacing_reg});
            addx_reg  <= addx;
            addz_reg  <= addz;
            scale_reg <= sc;
            p_reg     <= d_reg;
        end
    end

    // Stage 3: final add and output register.
    logic signed [POS_W-1:0] wx, wz;
    logic                    o_valid_reg;
    logic [POS_W-1:0]        posx_reg, posz_reg;
    logic [SCALE_W-1:0]      o_scale_reg;
    ctp_desc_t               o_reg;

    assign wx = (POS_W'(px_reg) <<< 1) + POS_W'(addx_reg);
    assign wz = (POS_W'(pz_reg) <<< 1) + POS_W'(addz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            posx_reg    <= wx << POS_SHIFT;
            posz_reg    <= wz << POS_SHIFT;
            o_scale_reg <= scale_reg;
            o_reg       <= p_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tuser  = o_reg.piece;
    assign m_axis_tlast  = o_reg.last;
    assign m_axis_tdata  = {5'd0, o_reg.rot, o_scale_reg, posz_reg, posx_reg, o_reg.idx};

    // Checks.
    a_last_is_filler: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == PIECE_FILLER)
        else $error("tlast on a placement that is not a filler");

    a_rot_only_trim: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != PIECE_TRIM |-> m_axis_tdata[122:121] == 2'd0)
        else $error("rotation set on a non-trim placement");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        seq_load |-> !seq_busy_reg && !div_busy_reg)
        else $error("sequencer loaded while busy");

    a_cross_first: assert property (@(posedge clk) disable iff (!rst_n)
        seq_load |=> phase_reg == PH_CROSS && lvl_reg == '0)
        else $error("run does not start with the cross");

endmodule
